FILE: hw/rtl/pidc_pkg.sv
// Shared widths, register codes, mode codes and stage structs of the PID controller.
package pidc_pkg;

  localparam int SAMPLE_W = 16;               // measured, error_in, rate_in
  localparam int GAIN_W   = 16;               // Q8.8 gains and setpoint
  localparam int ERR_W    = SAMPLE_W + 1;     // setpoint - measured
  localparam int OPB_W    = ERR_W + 2;        // e - 2*prev + prev2
  localparam int PROD_W   = GAIN_W + OPB_W;
  localparam int ACC_W    = PROD_W + 2;       // sum of four products
  localparam int FRAC_W   = 8;                // Q8.8 fraction bits
  localparam int DRIVE_W  = 32;
  localparam int U_W      = DRIVE_W + 2;      // raw drive before clamping
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 3 * SAMPLE_W;

  typedef enum logic [1:0] {
    MODE_POS      = 2'd0,
    MODE_DIRECT   = 2'd1,
    MODE_POS_RATE = 2'd2,
    MODE_INCR     = 2'd3
  } loop_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_GAIN_RATE = 3'd3,
    REG_SETPOINT  = 3'd4,
    REG_DRIVE_MAX = 3'd5,
    REG_DRIVE_MIN = 3'd6,
    REG_LOOP_MODE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic signed [GAIN_W-1:0]  gain_rate;
    logic signed [GAIN_W-1:0]  setpoint;
    logic signed [DRIVE_W-1:0] drive_max;
    logic signed [DRIVE_W-1:0] drive_min;
    loop_mode_e                loop_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
    logic signed [PROD_W-1:0] p3;
    logic                     incr;
  } prod_t;

endpackage

FILE: hw/rtl/pidc_err_stage.sv
// Error history, integral clamp and registered gain products of the PID controller.
module pidc_err_stage import pidc_pkg::*; #(
  parameter int INTEGRAL_LIMIT = 1000
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  cfg_t                       cfg_i,
  input  logic signed [SAMPLE_W-1:0] measured_i,
  input  logic signed [SAMPLE_W-1:0] error_in_i,
  input  logic signed [SAMPLE_W-1:0] rate_in_i,
  output prod_t                      prod_o
);

  localparam int SUM_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam int ADD_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
  localparam logic signed [ADD_W-1:0] LimPos = ADD_W'(INTEGRAL_LIMIT);
  localparam logic signed [ADD_W-1:0] LimNeg = -LimPos;

  logic signed [ERR_W-1:0] err_now_q, err_now_d;
  logic signed [ERR_W-1:0] err_prev_q, err_prev_d;
  logic signed [ERR_W-1:0] err_prev2_q, err_prev2_d;
  logic signed [SUM_W-1:0] err_sum_q, err_sum_d;
  prod_t                   prod_q, prod_d;

  logic                    incr;
  logic signed [ERR_W-1:0] e;
  logic signed [ADD_W-1:0] sum_raw, sum_clamped;
  logic signed [OPB_W-1:0] diff1, diff2, e_x, sum_x, rate_x;
  logic signed [OPB_W-1:0] opb0, opb1, opb2, opb3;

  always_comb begin
    incr = (cfg_i.loop_mode == MODE_INCR);
    if (cfg_i.loop_mode == MODE_DIRECT) begin
      e = ERR_W'(error_in_i);
    end else begin
      e = ERR_W'(cfg_i.setpoint) - ERR_W'(measured_i);
    end

    sum_raw = ADD_W'(err_sum_q) + ADD_W'(e);
    if (sum_raw > LimPos) begin
      sum_clamped = LimPos;
    end else if (sum_raw < LimNeg) begin
      sum_clamped = LimNeg;
    end else begin
      sum_clamped = sum_raw;
    end

    // err_now_q is the previous error in both forms, err_prev_q the one before
    e_x    = OPB_W'(e);
    diff1  = e_x - OPB_W'(err_now_q);
    diff2  = e_x - (OPB_W'(err_now_q) <<< 1) + OPB_W'(err_prev_q);
    sum_x  = OPB_W'($signed(sum_clamped[SUM_W-1:0]));
    rate_x = OPB_W'(rate_in_i);

    opb0 = incr ? diff1 : e_x;
    opb1 = incr ? e_x : sum_x;
    opb2 = incr ? diff2 : diff1;
    opb3 = (cfg_i.loop_mode == MODE_POS_RATE) ? rate_x : '0;

    prod_d.p0   = PROD_W'(cfg_i.gain_p) * PROD_W'(opb0);
    prod_d.p1   = PROD_W'(cfg_i.gain_i) * PROD_W'(opb1);
    prod_d.p2   = PROD_W'(cfg_i.gain_d) * PROD_W'(opb2);
    prod_d.p3   = PROD_W'(cfg_i.gain_rate) * PROD_W'(opb3);
    prod_d.incr = incr;

    err_now_d   = e;
    err_prev_d  = err_now_q;
    err_prev2_d = incr ? err_prev_q : err_prev2_q;
    err_sum_d   = incr ? err_sum_q : sum_clamped[SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_now_q   <= '0;
      err_prev_q  <= '0;
      err_prev2_q <= '0;
      err_sum_q   <= '0;
    end else if (en_i) begin
      err_now_q   <= err_now_d;
      err_prev_q  <= err_prev_d;
      err_prev2_q <= err_prev2_d;
      err_sum_q   <= err_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/pidc_out_stage.sv
// Product sum, Q8.8 scaling, incremental accumulate and output clamp of the PID controller.
module pidc_out_stage import pidc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  cfg_t                      cfg_i,
  input  prod_t                     prod_i,
  output logic signed [DRIVE_W-1:0] drive_o,
  output logic                      saturated_o
);

  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      sat_q, sat_d;
  logic signed [ACC_W-1:0]   acc, acc_sh;
  logic signed [U_W-1:0]     u, u_hi;
  logic                      over, under;

  always_comb begin
    acc = ACC_W'(prod_i.p0) + ACC_W'(prod_i.p1) + ACC_W'(prod_i.p2) + ACC_W'(prod_i.p3);
    // arithmetic shift floors toward minus infinity
    acc_sh = acc >>> FRAC_W;
    u = U_W'($signed(acc_sh[ACC_W-FRAC_W-1:0]));
    // the result register doubles as the kept output of the incremental form
    if (prod_i.incr) begin
      u = u + U_W'(drive_q);
    end

    over  = (u > U_W'(cfg_i.drive_max));
    u_hi  = over ? U_W'(cfg_i.drive_max) : u;
    under = (u_hi < U_W'(cfg_i.drive_min));
    drive_d = under ? cfg_i.drive_min : u_hi[DRIVE_W-1:0];
    sat_d   = over | under;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
      sat_q   <= 1'b0;
    end else if (en_i) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

  assign drive_o     = drive_q;
  assign saturated_o = sat_q;

endmodule

FILE: hw/rtl/pid_controller_multimode.sv
// Top level of the multimode PID controller: config registers, input register and pipeline control.
// One request per control tick gives one drive value. The block takes a request every
// cycle while the pipe advances and presents its result from the input register through the product
// register to the result register; a stalled output freezes the whole pipe, so throughput is one
// item per cycle while m_axis_tready_i stays high. loop_mode picks positional PID on setpoint
// minus measured (0), on error_in (1), the first form plus gain_rate*rate_in (2), or
// incremental PID on the kept output (3). Gains are signed Q8.8; the integral is clamped to
// +-INTEGRAL_LIMIT; the output is clamped to drive_max first and drive_min last, and the
// flag in tuser marks a clamped value. Write the registers only while no request is in flight.
module pid_controller_multimode import pidc_pkg::*; #(
  parameter int INTEGRAL_LIMIT = 1000
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // measured, error_in, rate_in
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [DRIVE_W-1:0]    m_axis_tdata_o,   // drive
  output logic                  m_axis_tuser_o    // saturated
);

  cfg_t cfg_q;

  logic                       advance;
  logic                       v0_q, v1_q, v2_q;
  logic signed [SAMPLE_W-1:0] measured_q, error_in_q, rate_in_q;
  prod_t                      prod;
  logic signed [DRIVE_W-1:0]  drive;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= '0;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
      cfg_q.gain_rate <= '0;
      cfg_q.setpoint  <= '0;
      cfg_q.drive_max <= {1'b0, {(DRIVE_W-1){1'b1}}};
      cfg_q.drive_min <= {1'b1, {(DRIVE_W-1){1'b0}}};
      cfg_q.loop_mode <= MODE_POS;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN_P:    cfg_q.gain_p    <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_I:    cfg_q.gain_i    <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_D:    cfg_q.gain_d    <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_RATE: cfg_q.gain_rate <= cfg_wdata_i[GAIN_W-1:0];
        REG_SETPOINT:  cfg_q.setpoint  <= cfg_wdata_i[GAIN_W-1:0];
        REG_DRIVE_MAX: cfg_q.drive_max <= cfg_wdata_i[DRIVE_W-1:0];
        REG_DRIVE_MIN: cfg_q.drive_min <= cfg_wdata_i[DRIVE_W-1:0];
        REG_LOOP_MODE: cfg_q.loop_mode <= loop_mode_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // advance all stages together whenever the result slot is free or being taken
  assign advance = !v2_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (advance) begin
      v0_q <= s_axis_tvalid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s_axis_tvalid_i) begin
      measured_q <= s_axis_tdata_i[SAMPLE_W-1:0];
      error_in_q <= s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W];
      rate_in_q  <= s_axis_tdata_i[3*SAMPLE_W-1:2*SAMPLE_W];
    end
  end

  pidc_err_stage #(
    .INTEGRAL_LIMIT(INTEGRAL_LIMIT)
  ) u_err_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance && v0_q),
    .cfg_i      (cfg_q),
    .measured_i (measured_q),
    .error_in_i (error_in_q),
    .rate_in_i  (rate_in_q),
    .prod_o     (prod)
  );

  pidc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance && v1_q),
    .cfg_i       (cfg_q),
    .prod_i      (prod),
    .drive_o     (drive),
    .saturated_o (m_axis_tuser_o)
  );

  assign s_axis_tready_o = advance;
  assign m_axis_tvalid_o = v2_q;
  assign m_axis_tdata_o  = drive;

endmodule
